/* sv/rbei_pkg.sv */
package rbei_pkg;

	localparam int CfgW  = 17;
	localparam int AddrW = 3;
	localparam int DataW = 32;

	localparam logic [CfgW-1:0] TimeStepRst = 17'd1092;
	localparam logic [CfgW-1:0] DampingRst  = 17'd45875;

	// register index, taken from paddr[2]
	localparam logic REG_TIME_STEP = 1'b0;
	localparam logic REG_DAMPING   = 1'b1;

	localparam int LATENCY = 6;

	typedef struct packed {
		logic signed [31:0] in_pos_x;
		logic signed [31:0] in_pos_y;
		logic signed [31:0] in_orientation;
		logic signed [31:0] in_vel_x;
		logic signed [31:0] in_vel_y;
		logic signed [31:0] in_ang_vel;
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] torque_in;
		logic [30:0]        inv_mass;
		logic [30:0]        inv_inertia;
		logic [3:0]         body_flags;
	} item_t;

	typedef struct packed {
		logic signed [31:0] out_pos_x;
		logic signed [31:0] out_pos_y;
		logic signed [31:0] out_orientation;
		logic signed [31:0] out_vel_x;
		logic signed [31:0] out_vel_y;
		logic signed [31:0] out_ang_vel;
		logic               last_body;
	} result_t;

	// clamp a wide sum to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [48:0] x);
		logic hi_ones;
		logic hi_zeros;
		hi_ones  = &x[48:31];
		hi_zeros = ~|x[48:31];
		if (hi_ones || hi_zeros)
			return x[31:0];
		else if (x[48])
			return 32'sh8000_0000;
		else
			return 32'sh7fff_ffff;
	endfunction

endpackage

/* sv/rbei_vel_lane.sv */
// v + floor(floor(f*k/2^16)*dt/2^16), saturated, or v when upd is low; three stages
module rbei_vel_lane (
	input  logic                             clk,
	input  logic signed [31:0]               f,
	input  logic [30:0]                      k,
	input  logic [rbei_pkg::CfgW-1:0]        dt,
	input  logic signed [31:0]               v,
	input  logic                             upd,
	output logic signed [31:0]               v_new,
	output logic                             upd_out
);

	logic signed [63:0] prod_s1;
	logic signed [31:0] v_s1;
	logic               upd_s1;
	logic signed [47:0] sc_s2;
	logic signed [31:0] v_s2;
	logic               upd_s2;
	logic signed [63:0] m1;
	logic signed [65:0] m2;
	logic signed [48:0] sum;

	assign m1  = f * $signed({1'b0, k});
	assign m2  = $signed(prod_s1[63:16]) * $signed({1'b0, dt});
	assign sum = 49'(v_s2) + 49'(sc_s2);

	always_ff @(posedge clk) begin
		prod_s1 <= m1;
		v_s1    <= v;
		upd_s1  <= upd;
		sc_s2   <= $signed(m2[63:16]);
		v_s2    <= v_s1;
		upd_s2  <= upd_s1;
		v_new   <= upd_s2 ? rbei_pkg::sat32(sum) : v_s2;
		upd_out <= upd_s2;
	end

endmodule

/* sv/rbei_pos_lane.sv */
// p + floor(floor(v*damp/2^16)*dt/2^16), saturated, or p when upd is low; three stages
module rbei_pos_lane (
	input  logic                             clk,
	input  logic signed [31:0]               v,
	input  logic [rbei_pkg::CfgW-1:0]        damp,
	input  logic [rbei_pkg::CfgW-1:0]        dt,
	input  logic signed [31:0]               p,
	input  logic                             upd,
	output logic signed [31:0]               p_new
);

	logic signed [33:0] a_s1;
	logic signed [31:0] p_s1;
	logic               upd_s1;
	logic signed [35:0] sc_s2;
	logic signed [31:0] p_s2;
	logic               upd_s2;
	logic signed [49:0] m1;
	logic signed [51:0] m2;
	logic signed [48:0] sum;

	assign m1  = v * $signed({1'b0, damp});
	assign m2  = a_s1 * $signed({1'b0, dt});
	assign sum = 49'(p_s2) + 49'(sc_s2);

	always_ff @(posedge clk) begin
		a_s1   <= $signed(m1[49:16]);
		p_s1   <= p;
		upd_s1 <= upd;
		sc_s2  <= $signed(m2[51:16]);
		p_s2   <= p_s1;
		upd_s2 <= upd_s1;
		p_new  <= upd_s2 ? rbei_pkg::sat32(sum) : p_s2;
	end

endmodule

/* sv/rigid_body_euler_integrator_top.sv */
// Channel   Handshake              Payload
// input     start (busy low)       item   (rbei_pkg::item_t)
// result    done, one-cycle strobe result (rbei_pkg::result_t)
// config    APB write/read         pwdata/prdata, paddr[2] selects register
//
// One item per cycle; busy is never raised. Each item goes through three
// stages for the velocity update (two multiplies, then add and clamp) and
// three for the position update on the new velocity.
// arst_n clears the valid pipe and loads the register reset values.
// The result side cannot stall, so the pipe never holds.
module rigid_body_euler_integrator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  rbei_pkg::item_t               item,
	output logic                          done,
	output rbei_pkg::result_t             result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rbei_pkg::AddrW-1:0]    paddr,
	input  logic [rbei_pkg::DataW-1:0]    pwdata,
	output logic [rbei_pkg::DataW-1:0]    prdata,
	output logic                          pready
);

	logic [rbei_pkg::CfgW-1:0] time_step_q;
	logic [rbei_pkg::CfgW-1:0] damping_q;

	logic accept;
	logic upd_lin;
	logic upd_ang;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;

	logic signed [31:0] pos_s1 [3];
	logic signed [31:0] pos_s2 [3];
	logic signed [31:0] pos_s3 [3];
	logic signed [31:0] vel_s4 [3];
	logic signed [31:0] vel_s5 [3];
	logic signed [31:0] vel_s6 [3];

	logic signed [31:0] vel_new [3];
	logic               vel_upd [3];
	logic signed [31:0] pos_new [3];

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign pready = 1'b1;

	// static or inactive bodies pass through; lock freezes the angular lane
	assign upd_lin = !item.body_flags[0] && item.body_flags[1];
	assign upd_ang = upd_lin && !item.body_flags[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= rbei_pkg::TimeStepRst;
			damping_q   <= rbei_pkg::DampingRst;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				rbei_pkg::REG_TIME_STEP: time_step_q <= pwdata[rbei_pkg::CfgW-1:0];
				rbei_pkg::REG_DAMPING:   damping_q   <= pwdata[rbei_pkg::CfgW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			rbei_pkg::REG_TIME_STEP: prdata = rbei_pkg::DataW'(time_step_q);
			rbei_pkg::REG_DAMPING:   prdata = rbei_pkg::DataW'(damping_q);
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		last_s1   <= item.body_flags[3];
		last_s2   <= last_s1;
		last_s3   <= last_s2;
		last_s4   <= last_s3;
		last_s5   <= last_s4;
		last_s6   <= last_s5;
		pos_s1[0] <= item.in_pos_x;
		pos_s1[1] <= item.in_pos_y;
		pos_s1[2] <= item.in_orientation;
		pos_s2    <= pos_s1;
		pos_s3    <= pos_s2;
		vel_s4    <= vel_new;
		vel_s5    <= vel_s4;
		vel_s6    <= vel_s5;
	end

	rbei_vel_lane u_vel_x (
		.clk(clk), .f(item.force_x), .k(item.inv_mass), .dt(time_step_q),
		.v(item.in_vel_x), .upd(upd_lin), .v_new(vel_new[0]), .upd_out(vel_upd[0])
	);
	rbei_vel_lane u_vel_y (
		.clk(clk), .f(item.force_y), .k(item.inv_mass), .dt(time_step_q),
		.v(item.in_vel_y), .upd(upd_lin), .v_new(vel_new[1]), .upd_out(vel_upd[1])
	);
	rbei_vel_lane u_vel_w (
		.clk(clk), .f(item.torque_in), .k(item.inv_inertia), .dt(time_step_q),
		.v(item.in_ang_vel), .upd(upd_ang), .v_new(vel_new[2]), .upd_out(vel_upd[2])
	);

	rbei_pos_lane u_pos_x (
		.clk(clk), .v(vel_new[0]), .damp(damping_q), .dt(time_step_q),
		.p(pos_s3[0]), .upd(vel_upd[0]), .p_new(pos_new[0])
	);
	rbei_pos_lane u_pos_y (
		.clk(clk), .v(vel_new[1]), .damp(damping_q), .dt(time_step_q),
		.p(pos_s3[1]), .upd(vel_upd[1]), .p_new(pos_new[1])
	);
	rbei_pos_lane u_pos_th (
		.clk(clk), .v(vel_new[2]), .damp(damping_q), .dt(time_step_q),
		.p(pos_s3[2]), .upd(vel_upd[2]), .p_new(pos_new[2])
	);

	assign done                   = valid_s6;
	assign result.out_pos_x       = pos_new[0];
	assign result.out_pos_y       = pos_new[1];
	assign result.out_orientation = pos_new[2];
	assign result.out_vel_x       = vel_s6[0];
	assign result.out_vel_y       = vel_s6[1];
	assign result.out_ang_vel     = vel_s6[2];
	assign result.last_body       = last_s6;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##6 done)
		else $error("item did not complete after pipeline latency");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##6 (result.last_body == $past(item.body_flags[3], 6)))
		else $error("last_body not aligned with its item");

	a_static: assert property (@(posedge clk) disable iff (!arst_n)
		(start && item.body_flags[0]) |-> ##6
		(result.out_pos_x == $past(item.in_pos_x, 6) &&
		 result.out_vel_y == $past(item.in_vel_y, 6) &&
		 result.out_ang_vel == $past(item.in_ang_vel, 6)))
		else $error("static body was modified");

	a_lock: assert property (@(posedge clk) disable iff (!arst_n)
		(start && item.body_flags[2]) |-> ##6
		(result.out_orientation == $past(item.in_orientation, 6) &&
		 result.out_ang_vel == $past(item.in_ang_vel, 6)))
		else $error("locked body changed its angular state");

endmodule
